/* rtl/core/cmig_pkg.sv */
// Shared types and constants of the cylinder mesh index generator.
package cmig_pkg;

  localparam int unsigned IdxW        = 21;
  localparam int unsigned SegW        = 11;
  localparam int unsigned MaxSegments = 1024;

  typedef enum logic {
    CFG_RADIAL = 1'b0,
    CFG_HEIGHT = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    REGION_SIDE   = 2'd0,
    REGION_BOTTOM = 2'd1,
    REGION_TOP    = 2'd2
  } region_e;

  typedef struct packed {
    logic [IdxW-1:0] vertex_a;
    logic [IdxW-1:0] vertex_b;
    logic [IdxW-1:0] vertex_c;
    region_e         region;
    logic            last_of_mesh;
  } tri_t;

endpackage

/* rtl/core/cmig_fifo.sv */
// Two-entry queue used between the front side, the generator and the result side.
module cmig_fifo #(
  parameter int unsigned Width = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  logic [Width-1:0] mem_q [2];
  logic [1:0]       cnt_q, cnt_d;
  logic             wptr_q, rptr_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign data_o  = mem_q[rptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= 2'd0;
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) wptr_q <= ~wptr_q;
      if (do_pop)  rptr_q <= ~rptr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wptr_q] <= data_i;
  end

endmodule

/* rtl/core/cmig_tri_gen.sv */
// Back end: segment registers, sequence counters and triangle index arithmetic.
module cmig_tri_gen #(
  parameter int unsigned MAX_SEGMENTS = cmig_pkg::MaxSegments
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  cmig_pkg::cfg_idx_e        cfg_idx_i,
  input  logic [cmig_pkg::SegW-1:0] cfg_wdata_i,
  input  logic                      req_valid_i,
  input  logic                      req_restart_i,
  output logic                      req_pop_o,
  input  logic                      res_full_i,
  output logic                      res_push_o,
  output cmig_pkg::tri_t            res_o
);

  localparam int unsigned IdxW   = cmig_pkg::IdxW;
  localparam int unsigned SegW   = cmig_pkg::SegW;
  localparam int unsigned SegMax = (1 << SegW) - 1;
  localparam int unsigned MaxEff = (MAX_SEGMENTS > SegMax) ? SegMax : MAX_SEGMENTS;

  typedef enum logic [2:0] {
    PH_SIDE   = 3'b001,
    PH_BOTTOM = 3'b010,
    PH_TOP    = 3'b100
  } phase_e;

  logic [SegW-1:0] radial_q, height_q;
  logic [SegW-1:0] r, h;
  phase_e          phase_q, phase_d, phase_c;
  logic [SegW-1:0] row_q, row_d, row_c;
  logic [SegW-1:0] col_q, col_d, col_c;
  logic            half_q, half_d, half_c;
  logic [IdxW-1:0] base_q, base_d, base_c;
  logic [IdxW-1:0] stride, cur, nxt, bc, tc;
  logic            col_end, row_end, go;

  function automatic logic [SegW-1:0] eff_count(input logic [SegW-1:0] v);
    logic [SegW-1:0] res;
    res = v;
    if (v == '0) begin
      res = SegW'(1);
    end else if (int'(v) > int'(MaxEff)) begin
      res = SegW'(MaxEff);
    end
    return res;
  endfunction

  assign r = eff_count(radial_q);
  assign h = eff_count(height_q);

  assign go         = req_valid_i & ~res_full_i;
  assign req_pop_o  = go;
  assign res_push_o = go;

  // restart rewinds before the triangle is formed
  always_comb begin
    phase_c = req_restart_i ? PH_SIDE : phase_q;
    row_c   = req_restart_i ? '0 : row_q;
    col_c   = req_restart_i ? '0 : col_q;
    half_c  = req_restart_i ? 1'b0 : half_q;
    base_c  = req_restart_i ? '0 : base_q;
  end

  assign stride  = IdxW'(r) + IdxW'(1);
  assign cur     = base_c + IdxW'(col_c);
  assign nxt     = cur + stride;
  assign bc      = base_c + stride;
  assign tc      = bc + IdxW'(r) + IdxW'(2);
  assign col_end = ({1'b0, col_c} + (SegW+1)'(1)) >= {1'b0, r};
  assign row_end = ({1'b0, row_c} + (SegW+1)'(1)) >= {1'b0, h};

  always_comb begin
    phase_d = phase_c;
    row_d   = row_c;
    col_d   = col_c;
    half_d  = half_c;
    base_d  = base_c;
    res_o.last_of_mesh = 1'b0;
    unique case (phase_c)
      PH_BOTTOM: begin
        res_o.region   = cmig_pkg::REGION_BOTTOM;
        res_o.vertex_a = bc;
        res_o.vertex_b = bc + IdxW'(col_c) + IdxW'(2);
        res_o.vertex_c = bc + IdxW'(col_c) + IdxW'(1);
        if (col_end) begin
          col_d   = '0;
          phase_d = PH_TOP;
        end else begin
          col_d = col_c + SegW'(1);
        end
      end
      PH_TOP: begin
        res_o.region   = cmig_pkg::REGION_TOP;
        res_o.vertex_a = tc;
        res_o.vertex_b = tc + IdxW'(col_c) + IdxW'(1);
        res_o.vertex_c = tc + IdxW'(col_c) + IdxW'(2);
        if (col_end) begin
          res_o.last_of_mesh = 1'b1;
          phase_d = PH_SIDE;
          row_d   = '0;
          col_d   = '0;
          half_d  = 1'b0;
          base_d  = '0;
        end else begin
          col_d = col_c + SegW'(1);
        end
      end
      default: begin
        res_o.region = cmig_pkg::REGION_SIDE;
        res_o.vertex_b = nxt;
        if (!half_c) begin
          res_o.vertex_a = cur;
          res_o.vertex_c = cur + IdxW'(1);
          half_d = 1'b1;
        end else begin
          res_o.vertex_a = cur + IdxW'(1);
          res_o.vertex_c = nxt + IdxW'(1);
          half_d = 1'b0;
          if (col_end) begin
            col_d  = '0;
            base_d = base_c + stride;
            if (row_end) begin
              row_d   = '0;
              phase_d = PH_BOTTOM;
            end else begin
              row_d = row_c + SegW'(1);
            end
          end else begin
            col_d = col_c + SegW'(1);
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radial_q <= SegW'(16);
      height_q <= SegW'(1);
      phase_q  <= PH_SIDE;
      row_q    <= '0;
      col_q    <= '0;
      half_q   <= 1'b0;
      base_q   <= '0;
    end else if (cfg_we_i) begin
      // any register write rewinds the sequence
      unique case (cfg_idx_i)
        cmig_pkg::CFG_RADIAL: radial_q <= cfg_wdata_i;
        cmig_pkg::CFG_HEIGHT: height_q <= cfg_wdata_i;
        default: ;
      endcase
      phase_q <= PH_SIDE;
      row_q   <= '0;
      col_q   <= '0;
      half_q  <= 1'b0;
      base_q  <= '0;
    end else if (go) begin
      phase_q <= phase_d;
      row_q   <= row_d;
      col_q   <= col_d;
      half_q  <= half_d;
      base_q  <= base_d;
    end
  end

endmodule

/* rtl/core/cylinder_mesh_index_gen_unit.sv */
// Top level of the capped cylinder triangle index generator.
//
// Each request pushed on the input queue (push/full, field restart_i) yields
// exactly one triangle on the result queue (empty/pop): three vertex indices,
// a region code (side, bottom cap, top cap) and a last-of-mesh flag. The side
// grid comes first, then the bottom cap fan, then the top cap fan; after the
// last top cap triangle the sequence starts over. restart_i = 1 rewinds and
// emits the first side triangle for that same request.
// Configuration: cfg_we_i with cfg_idx_i (0 radial, 1 height segments) and
// cfg_wdata_i; a write takes effect at once and rewinds the sequence.
// Path: a request waits in the request queue, the generator forms its
// triangle combinationally from the queue head and the result queue registers
// it. Throughput: one triangle per cycle while the result queue has room, set
// by the counter and adder step between 2-entry request and result queues.
// Reset: radial 16, height 1, sequence at the first side triangle, queues empty.
// When the receiver stops popping, the result queue fills, the generator halts
// and full rises once the request queue holds two requests.
module cylinder_mesh_index_gen_unit #(
  parameter int unsigned MAX_SEGMENTS = cmig_pkg::MaxSegments
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  cmig_pkg::cfg_idx_e        cfg_idx_i,
  input  logic [cmig_pkg::SegW-1:0] cfg_wdata_i,
  input  logic                      push,
  output logic                      full,
  input  logic                      restart_i,
  output logic                      empty,
  input  logic                      pop,
  output logic [cmig_pkg::IdxW-1:0] vertex_a_o,
  output logic [cmig_pkg::IdxW-1:0] vertex_b_o,
  output logic [cmig_pkg::IdxW-1:0] vertex_c_o,
  output logic [1:0]                region_o,
  output logic                      last_of_mesh_o
);

  localparam int unsigned TriW = $bits(cmig_pkg::tri_t);

  logic           req_empty, req_pop, req_restart;
  logic           res_full, res_push;
  cmig_pkg::tri_t res_in, res_out;
  logic [TriW-1:0] res_out_bits;

  cmig_fifo #(.Width(1)) u_req_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (restart_i),
    .full_o  (full),
    .pop_i   (req_pop),
    .data_o  (req_restart),
    .empty_o (req_empty)
  );

  cmig_tri_gen #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_gen (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .req_valid_i   (~req_empty),
    .req_restart_i (req_restart),
    .req_pop_o     (req_pop),
    .res_full_i    (res_full),
    .res_push_o    (res_push),
    .res_o         (res_in)
  );

  cmig_fifo #(.Width(TriW)) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_out_bits),
    .empty_o (empty)
  );

  assign res_out        = cmig_pkg::tri_t'(res_out_bits);
  assign vertex_a_o     = res_out.vertex_a;
  assign vertex_b_o     = res_out.vertex_b;
  assign vertex_c_o     = res_out.vertex_c;
  assign region_o       = res_out.region;
  assign last_of_mesh_o = res_out.last_of_mesh;

endmodule

/* rtl/core/cmig_checker.sv */
// Port-level assertions for the cylinder mesh index generator, bound to the top level.
module cmig_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      full,
  input logic                      empty,
  input logic                      pop,
  input logic [cmig_pkg::IdxW-1:0] vertex_a_o,
  input logic [cmig_pkg::IdxW-1:0] vertex_b_o,
  input logic [cmig_pkg::IdxW-1:0] vertex_c_o,
  input logic [1:0]                region_o,
  input logic                      last_of_mesh_o
);

  localparam logic [cmig_pkg::IdxW-1:0] One = cmig_pkg::IdxW'(1);

  // both queues come out of reset empty
  a_reset_empty: assert property (@(posedge clk_i) !rst_ni ##1 !rst_ni |-> empty && !full)
    else $error("queues not empty in reset");

  // a stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(vertex_a_o) && $stable(region_o))
    else $error("result changed while stalled");

  a_last_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && last_of_mesh_o |-> region_o == cmig_pkg::REGION_TOP)
    else $error("last flag outside top cap");

  // side triangles share an edge step of one; cap fans step between b and c
  a_side_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && region_o == cmig_pkg::REGION_SIDE |->
      vertex_c_o == vertex_a_o + One || vertex_c_o == vertex_b_o + One)
    else $error("bad side triangle");

  a_cap_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && region_o == cmig_pkg::REGION_BOTTOM |-> vertex_b_o == vertex_c_o + One)
    else $error("bad bottom cap triangle");

endmodule

bind cylinder_mesh_index_gen_unit cmig_checker u_cmig_checker (.*);

/* test/tb_cylinder_mesh_index_gen_unit.sv */
// Self-checking testbench for the cylinder mesh index generator unit.
`timescale 1ns / 1ps

module tb_cylinder_mesh_index_gen_unit;

  localparam int unsigned IdxW    = cmig_pkg::IdxW;
  localparam int unsigned SegW    = cmig_pkg::SegW;
  localparam int unsigned IdxMask = (1 << IdxW) - 1;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  cmig_pkg::cfg_idx_e cfg_idx_i = cmig_pkg::CFG_RADIAL;
  logic [SegW-1:0]    cfg_wdata_i = '0;
  logic               push = 1'b0;
  logic               full;
  logic               restart_i = 1'b0;
  logic               empty;
  logic               pop = 1'b0;
  logic [IdxW-1:0]    vertex_a_o;
  logic [IdxW-1:0]    vertex_b_o;
  logic [IdxW-1:0]    vertex_c_o;
  logic [1:0]         region_o;
  logic               last_of_mesh_o;

  cylinder_mesh_index_gen_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .push           (push),
    .full           (full),
    .restart_i      (restart_i),
    .empty          (empty),
    .pop            (pop),
    .vertex_a_o     (vertex_a_o),
    .vertex_b_o     (vertex_b_o),
    .vertex_c_o     (vertex_c_o),
    .region_o       (region_o),
    .last_of_mesh_o (last_of_mesh_o)
  );

  always #1 clk_i = ~clk_i;

  // Generator state mirror
  logic [SegW-1:0]   radial_q = 11'd16;
  logic [SegW-1:0]   height_q = 11'd1;
  cmig_pkg::region_e phase_q = cmig_pkg::REGION_SIDE;
  int unsigned       row_cnt = 0;
  int unsigned       col_cnt = 0;
  bit                half_q = 1'b0;
  logic [IdxW-1:0]   row_base_q = '0;

  cmig_pkg::tri_t tri_fifo[$];
  int unsigned    err_cnt = 0;
  int unsigned    send_gap_pct = 7;
  int unsigned    pop_stall_pct = 79;

  function automatic int unsigned clamp_seg(logic [SegW-1:0] v);
    if (v == 0) return 1;
    if (v > cmig_pkg::MaxSegments) return cmig_pkg::MaxSegments;
    return 32'(v);
  endfunction

  function automatic void rewind_mesh();
    phase_q = cmig_pkg::REGION_SIDE;
    row_cnt = 0;
    col_cnt = 0;
    half_q = 1'b0;
    row_base_q = '0;
  endfunction

  // Next triangle of the index list; advances the mirrored counters.
  function automatic cmig_pkg::tri_t next_tri(bit rst);
    int unsigned r, h, stride, cur, nxt, hub, rim;
    cmig_pkg::tri_t t;
    r = clamp_seg(radial_q);
    h = clamp_seg(height_q);
    stride = r + 1;
    if (rst) rewind_mesh();
    t.last_of_mesh = 1'b0;
    t.region = phase_q;
    case (phase_q)
      cmig_pkg::REGION_SIDE: begin
        cur = (row_base_q + col_cnt) & IdxMask;
        nxt = (cur + stride) & IdxMask;
        if (!half_q) begin
          t.vertex_a = IdxW'(cur);
          t.vertex_b = IdxW'(nxt);
          t.vertex_c = IdxW'(cur + 1);
          half_q = 1'b1;
        end else begin
          t.vertex_a = IdxW'(cur + 1);
          t.vertex_b = IdxW'(nxt);
          t.vertex_c = IdxW'(nxt + 1);
          half_q = 1'b0;
          if (col_cnt + 1 < r) begin
            col_cnt++;
          end else begin
            col_cnt = 0;
            row_base_q = IdxW'(row_base_q + stride);
            if (row_cnt + 1 < h) begin
              row_cnt++;
            end else begin
              row_cnt = 0;
              phase_q = cmig_pkg::REGION_BOTTOM;
            end
          end
        end
      end
      cmig_pkg::REGION_BOTTOM: begin
        hub = (row_base_q + stride) & IdxMask;
        rim = hub + 1;
        t.vertex_a = IdxW'(hub);
        t.vertex_b = IdxW'(rim + col_cnt + 1);
        t.vertex_c = IdxW'(rim + col_cnt);
        if (col_cnt + 1 < r) begin
          col_cnt++;
        end else begin
          col_cnt = 0;
          phase_q = cmig_pkg::REGION_TOP;
        end
      end
      default: begin
        hub = (row_base_q + stride + r + 2) & IdxMask;
        rim = hub + 1;
        t.vertex_a = IdxW'(hub);
        t.vertex_b = IdxW'(rim + col_cnt);
        t.vertex_c = IdxW'(rim + col_cnt + 1);
        if (col_cnt + 1 < r) begin
          col_cnt++;
        end else begin
          t.last_of_mesh = 1'b1;
          rewind_mesh();
        end
      end
    endcase
    return t;
  endfunction

  task automatic report_mismatch(string msg);
    if (err_cnt < 50) $display("ERROR @%0t: %s", $time, msg);
    err_cnt++;
  endtask

  task automatic check_field(string name, int unsigned got, int unsigned want);
    if (got != want) report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  // Result side: sample pre-edge outputs, then pick the next pop at random
  always @(posedge clk_i) begin
    cmig_pkg::tri_t want;
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (tri_fifo.size() == 0) begin
          report_mismatch("triangle with no request outstanding");
        end else begin
          want = tri_fifo.pop_front();
          check_field("vertex_a", vertex_a_o, want.vertex_a);
          check_field("vertex_b", vertex_b_o, want.vertex_b);
          check_field("vertex_c", vertex_c_o, want.vertex_c);
          check_field("region", region_o, want.region);
          check_field("last_of_mesh", last_of_mesh_o, want.last_of_mesh);
        end
      end
      pop <= ($urandom_range(99) >= pop_stall_pct);
    end
  end

  task automatic send_request(bit rst);
    cmig_pkg::tri_t t;
    while ($urandom_range(99) < send_gap_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    restart_i <= rst;
    do @(posedge clk_i); while (full);
    t = next_tri(rst);
    tri_fifo = {tri_fifo, t};
  endtask

  // Stop requesting and wait for every outstanding triangle
  task automatic drain();
    push <= 1'b0;
    while (tri_fifo.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Registers are only written with nothing in flight
  task automatic write_cfg(cmig_pkg::cfg_idx_e idx, logic [SegW-1:0] val);
    drain();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    if (idx == cmig_pkg::CFG_RADIAL) radial_q = val;
    else height_q = val;
    rewind_mesh();
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic test_reset_defaults();
    send_request(1'b0);
    send_request(1'b0);
    send_request(1'b0);
    send_request(1'b1);
    drain();
  endtask

  // One quad: side pair, one bottom, one top (last), then wrap to side
  task automatic test_single_quad();
    write_cfg(cmig_pkg::CFG_RADIAL, 11'd1);
    write_cfg(cmig_pkg::CFG_HEIGHT, 11'd1);
    repeat (5) send_request(1'b0);
    drain();
  endtask

  // Zero segment counts behave as one
  task automatic test_zero_counts();
    write_cfg(cmig_pkg::CFG_RADIAL, 11'd0);
    write_cfg(cmig_pkg::CFG_HEIGHT, 11'd0);
    send_request(1'b0);
    send_request(1'b0);
    send_request(1'b1);
    send_request(1'b0);
    drain();
  endtask

  // Counts above the maximum clamp to it
  task automatic test_clamp_counts();
    write_cfg(cmig_pkg::CFG_RADIAL, 11'h7ff);
    write_cfg(cmig_pkg::CFG_HEIGHT, 11'h7ff);
    send_request(1'b0);
    send_request(1'b0);
    send_request(1'b1);
    write_cfg(cmig_pkg::CFG_RADIAL, 11'd1025);
    write_cfg(cmig_pkg::CFG_HEIGHT, 11'd3);
    send_request(1'b0);
    send_request(1'b0);
    drain();
  endtask

  function automatic logic [SegW-1:0] pick_count();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 5) return '0;
    if (roll < 15) return SegW'($urandom_range(2047));
    return SegW'($urandom_range(1, 6));
  endfunction

  // Random meshes: mostly uninterrupted walks, with occasional rewinds
  task automatic test_random_meshes(int unsigned total);
    int unsigned sent, mesh_len, lim, batch, roll;
    sent = 0;
    while (sent < total) begin
      drain();
      roll = $urandom_range(2);
      if (roll != 1) write_cfg(cmig_pkg::CFG_RADIAL, pick_count());
      if (roll != 0) write_cfg(cmig_pkg::CFG_HEIGHT, pick_count());
      mesh_len = 2 * clamp_seg(radial_q) * clamp_seg(height_q) + 2 * clamp_seg(radial_q);
      lim = mesh_len * 2 + 2;
      if (lim > 120) lim = 120;
      batch = $urandom_range(1, lim);
      if (batch > total - sent) batch = total - sent;
      repeat (batch) begin
        send_request($urandom_range(99) < 3);
        sent++;
      end
    end
    drain();
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_single_quad();
    test_zero_counts();
    test_clamp_counts();

    test_random_meshes(620);
    send_gap_pct = 79;
    pop_stall_pct = 7;
    test_random_meshes(620);
    send_gap_pct = 0;
    pop_stall_pct = 0;
    test_random_meshes(620);

    repeat (10) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("cylinder_mesh_index_gen_unit: match");
    end else begin
      $display("cylinder_mesh_index_gen_unit: mismatch");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("cylinder_mesh_index_gen_unit: mismatch");
    $finish;
  end

endmodule
